@@ hw/rtl/pcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_pkg : shared types and helpers for the percent decoder
// Item structs, queue entry layout, character codes and hex digit helpers.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // entries in the queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 4;

  // most result items one input item can cause
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       bad_escape;
  } out_item_t;

  // slot 0 leaves first; cnt is the number of slots in use (1 to 3)
  typedef struct packed {
    out_item_t [MAX_RES-1:0] res;
    logic      [1:0]         cnt;
  } pcd_entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  // valid for hex digits only; letters have low nibble 1..6 in either case
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pcd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_front : escape tracker and classifier
// Tracks the escape phase across input items and turns each accepted item
// into a queue entry of up to three result items.
// ----------------------------------------------------------------------------
module pcd_front
  import pcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire in_item_t   item,
  output logic            push,
  output pcd_entry_t      entry
);

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HELD = 3'b100
  } esc_state_t;

  esc_state_t  state_r, state_nxt;
  logic [7:0]  held_r, held_nxt;

  logic        f_emit;
  logic        f_pend;
  out_item_t   f_item;
  out_item_t   pct_bad;
  logic        b_hex;

  // plain decode of a byte with nothing pending
  always_comb begin
    f_emit = 1'b1;
    f_pend = 1'b0;
    f_item = '{out_byte: item.in_byte, out_last: item.in_last, bad_escape: 1'b0};
    if (item.in_byte == CHAR_PLUS) begin
      f_item.out_byte = CHAR_SPACE;
    end else if (item.in_byte == CHAR_PCT) begin
      if (item.in_last) begin
        f_item.bad_escape = 1'b1;
      end else begin
        f_emit = 1'b0;
        f_pend = 1'b1;
      end
    end
  end

  assign b_hex   = is_hex(item.in_byte);
  assign pct_bad = '{out_byte: CHAR_PCT, out_last: 1'b0, bad_escape: 1'b1};

  always_comb begin
    entry     = '0;
    state_nxt = state_r;
    held_nxt  = held_r;
    unique case (state_r)
      ESC_PCT: begin
        if (b_hex && !item.in_last) begin
          held_nxt  = item.in_byte;
          state_nxt = ESC_HELD;
        end else begin
          entry.res[0] = pct_bad;
          entry.res[1] = f_item;
          entry.cnt    = f_emit ? 2'd2 : 2'd1;
          state_nxt    = f_pend ? ESC_PCT : ESC_IDLE;
        end
      end
      ESC_HELD: begin
        if (b_hex) begin
          entry.res[0] = '{out_byte: {hex_val(held_r), hex_val(item.in_byte)},
                           out_last: item.in_last, bad_escape: 1'b0};
          entry.cnt    = 2'd1;
          state_nxt    = ESC_IDLE;
        end else begin
          entry.res[0] = pct_bad;
          entry.res[1] = '{out_byte: held_r, out_last: 1'b0, bad_escape: 1'b0};
          entry.res[2] = f_item;
          entry.cnt    = f_emit ? 2'd3 : 2'd2;
          state_nxt    = f_pend ? ESC_PCT : ESC_IDLE;
        end
      end
      default: begin
        entry.res[0] = f_item;
        entry.cnt    = f_emit ? 2'd1 : 2'd0;
        state_nxt    = f_pend ? ESC_PCT : ESC_IDLE;
      end
    endcase
  end

  assign push = accept && (entry.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ESC_IDLE;
      held_r  <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/pcd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_queue : short entry queue between front and back
// Register-based FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module pcd_queue
  import pcd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
)(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire pcd_entry_t push_entry,
  input  wire logic       pop,
  output logic            head_valid,
  output pcd_entry_t      head_entry,
  output logic            full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pcd_entry_t       mem_r [DEPTH];
  logic [AW:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]      rd_ptr_r, rd_ptr_nxt;

  assign full       = (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]) &&
                      (wr_ptr_r[AW] != rd_ptr_r[AW]);
  assign head_valid = (wr_ptr_r != rd_ptr_r);
  assign head_entry = mem_r[rd_ptr_r[AW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (AW+1)'(1);
  assign rd_ptr_nxt = rd_ptr_r + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= push_entry;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/pcd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_back : result sequencer
// Walks the slots of the head entry, one result item per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module pcd_back
  import pcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire pcd_entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic       load;
  logic       end_slot;

  assign load     = head_valid && (!out_valid_r || !out_stall);
  assign end_slot = (idx_r == (head_entry.cnt - 2'd1));
  assign pop      = load && end_slot;
  assign idx_nxt  = end_slot ? 2'd0 : (idx_r + 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= head_entry.res[idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

@@ hw/rtl/percent_decoder_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// percent_decoder_core : form-urlencoded percent decoder
// Decodes '+' to space and %XX escapes to bytes; malformed escapes pass the
// '%' through flagged and replay the held bytes.
//
//   port group | direction | payload     | flow control
//   in_        | input     | in_item_t   | in_valid / in_stall
//   out_       | output    | out_item_t  | out_valid / out_stall
//
// An input item is taken every cycle while the entry queue has room.
// Results leave at one per cycle from the output register while out_stall
// is low, so an item that causes two or three results holds the back until
// all of them have left. The first result of an item is registered in the
// queue and then in the output register. Synchronous reset empties the queue
// and output register and clears the escape phase. in_stall rises only when
// the queue is full.
module percent_decoder_core
  import pcd_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
)(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic       accept;
  logic       push;
  pcd_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  pcd_entry_t head_entry;
  logic       full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  pcd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .entry  (push_entry)
  );

  pcd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .full       (full)
  );

  pcd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

@@ hw/rtl/pcd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_checker : port-level checks for the percent decoder
// Watches the handshake ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module pcd_checker
  import pcd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // reset leaves nothing on the result channel
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty queue after reset takes input at once
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // hold the payload of a stalled result
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result payload changed while stalled");

  // a flagged item is always the literal percent
  a_bad_is_pct: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.bad_escape |-> out_item.out_byte == CHAR_PCT)
    else $error("bad escape flag on a byte other than percent");

endmodule

bind percent_decoder_core pcd_checker u_pcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
